### rtl/core/iirlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirlp_pkg
// Shared constants, coefficient tables and control types of the selectable
// order IIR low-pass filter.
// ----------------------------------------------------------------------------
package iirlp_pkg;

    // default sizes handed to the top level parameters
    localparam int NUM_CHANNELS_DEF = 2;
    localparam int MAX_TAPS_DEF     = 9;
    localparam int SAMPLE_WIDTH_DEF = 24;

    // coefficient table shape and datapath widths
    localparam int ROM_TAPS   = 9;
    localparam int TAP_IDX_W  = $clog2(ROM_TAPS);
    localparam int COEF_W     = 38;   // signed Q6.32 (wide feedback taps)
    localparam int Y_W        = 32;   // feedback history, signed Q18.14
    localparam int HALF_W     = 16;   // feedback words are split in two halves
    localparam int ACC_W      = 76;   // exact sum, 46 fraction bits
    localparam int FRAC_SHIFT = 32;   // Q.46 -> Q.14

    // rounding bias: one half of the dropped fraction
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << (FRAC_SHIFT - 1));

    // order register codes
    localparam logic [1:0] ORD_SECOND = 2'd0;
    localparam logic [1:0] ORD_FOURTH = 2'd1;
    localparam logic [1:0] ORD_EIGHTH = 2'd2;

    // which partial product the mac forms in a cycle
    typedef enum logic [1:0] {
        PH_X,    // feed-forward: b * x
        PH_YH,   // feedback upper half: a * y[31:16], weight 2^16
        PH_YL    // feedback lower half: a * y[15:0]
    } phase_t;

    // control from the sequencer to the mac
    typedef struct packed {
        logic                 clear;  // load rounding bias into the accumulator
        logic                 term;   // form a product this cycle
        phase_t               phase;
        logic [1:0]           sel;    // effective order code
        logic [TAP_IDX_W-1:0] tap;
    } mac_ctrl_t;

    // tap count of an order code, before clipping to the ring size
    function automatic logic [3:0] base_taps(input logic [1:0] sel);
        logic [3:0] n;
        unique case (sel)
            ORD_FOURTH: n = 4'd5;
            ORD_EIGHTH: n = 4'd9;
            default:    n = 4'd3;
        endcase
        return n;
    endfunction

    // feed-forward coefficients
    function automatic logic signed [COEF_W-1:0] coef_b(input logic [1:0] sel,
                                                       input logic [TAP_IDX_W-1:0] tap);
        logic signed [COEF_W-1:0] c;
        unique case ({sel, tap})
            {ORD_SECOND, 4'd0}: c = 38'sd86255828;
            {ORD_SECOND, 4'd1}: c = 38'sd172515951;
            {ORD_SECOND, 4'd2}: c = 38'sd86255828;
            {ORD_FOURTH, 4'd0}: c = 38'sd1786706;
            {ORD_FOURTH, 4'd1}: c = 38'sd7146826;
            {ORD_FOURTH, 4'd2}: c = 38'sd10720238;
            {ORD_FOURTH, 4'd3}: c = 38'sd7146826;
            {ORD_FOURTH, 4'd4}: c = 38'sd1786706;
            {ORD_EIGHTH, 4'd1}: c = 38'sd4295;
            {ORD_EIGHTH, 4'd2}: c = 38'sd21475;
            {ORD_EIGHTH, 4'd3}: c = 38'sd42950;
            {ORD_EIGHTH, 4'd4}: c = 38'sd51540;
            {ORD_EIGHTH, 4'd5}: c = 38'sd42950;
            {ORD_EIGHTH, 4'd6}: c = 38'sd21475;
            {ORD_EIGHTH, 4'd7}: c = 38'sd4295;
            default:            c = '0;
        endcase
        return c;
    endfunction

    // feedback coefficients, tap zero is never used
    function automatic logic signed [COEF_W-1:0] coef_a(input logic [1:0] sel,
                                                       input logic [TAP_IDX_W-1:0] tap);
        logic signed [COEF_W-1:0] c;
        unique case ({sel, tap})
            {ORD_SECOND, 4'd1}: c = -38'sd6704521258;
            {ORD_SECOND, 4'd2}: c = 38'sd2754585865;
            {ORD_FOURTH, 4'd1}: c = -38'sd13660736190;
            {ORD_FOURTH, 4'd2}: c = 38'sd16583701954;
            {ORD_FOURTH, 4'd3}: c = -38'sd9071636649;
            {ORD_FOURTH, 4'd4}: c = 38'sd1882333842;
            {ORD_EIGHTH, 4'd1}: c = -38'sd27446408685;
            {ORD_EIGHTH, 4'd2}: c = 38'sd77310863027;
            {ORD_EIGHTH, 4'd3}: c = -38'sd125288916193;
            {ORD_EIGHTH, 4'd4}: c = 38'sd127695283290;
            {ORD_EIGHTH, 4'd5}: c = -38'sd83776051528;
            {ORD_EIGHTH, 4'd6}: c = 38'sd34535814847;
            {ORD_EIGHTH, 4'd7}: c = -38'sd8176196097;
            {ORD_EIGHTH, 4'd8}: c = 38'sd850833021;
            default:            c = '0;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/iirlp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirlp_if
// Valid/ready channels of the filter: sample items in, filtered items out,
// and the order register write channel.
// ----------------------------------------------------------------------------

// sample items into the filter
interface iirlp_in_if #(
    parameter int SAMPLE_WIDTH = iirlp_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           channel;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

// filtered items out of the filter
interface iirlp_out_if #(
    parameter int SAMPLE_WIDTH = iirlp_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           channel_out;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;

    modport source (output valid, output channel_out, output sample_out,
                    output saturated, input ready);
    modport sink   (input valid, input channel_out, input sample_out,
                    input saturated, output ready);
endinterface

// order register writes
interface iirlp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] order_select;

    modport source (output valid, output order_select, input ready);
    modport sink   (input valid, input order_select, output ready);
endinterface

### rtl/core/iirlp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirlp_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module iirlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/iirlp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirlp_mac
// Shared multiply-accumulate of the filter: one coefficient times one operand
// per cycle, exact wide accumulation, then rounding to Q.14 and saturation.
// ----------------------------------------------------------------------------
module iirlp_mac #(
    parameter int SAMPLE_WIDTH = iirlp_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  iirlp_pkg::mac_ctrl_t                ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0]      x_data,
    input  logic                                x_valid,
    input  logic signed [iirlp_pkg::Y_W-1:0]    y_data,
    input  logic                                y_valid,
    output logic signed [iirlp_pkg::Y_W-1:0]    y_hist,
    output logic signed [SAMPLE_WIDTH-1:0]      y_out,
    output logic                                sat
);

    import iirlp_pkg::*;

    localparam int OP_W   = (SAMPLE_WIDTH > HALF_W + 1) ? SAMPLE_WIDTH : HALF_W + 1;
    localparam int PROD_W = COEF_W + OP_W;
    localparam int R_W    = ACC_W - FRAC_SHIFT;

    localparam logic signed [R_W-1:0] HMAX = {{(R_W - Y_W + 1){1'b0}}, {(Y_W - 1){1'b1}}};
    localparam logic signed [R_W-1:0] HMIN = {{(R_W - Y_W + 1){1'b1}}, {(Y_W - 1){1'b0}}};
    localparam logic signed [R_W-1:0] OMAX =
        {{(R_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [R_W-1:0] OMIN =
        {{(R_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    logic signed [OP_W-1:0]   op;
    logic signed [COEF_W-1:0] coef;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_en_reg;
    logic                     prod_neg_reg;
    logic                     prod_hi_reg;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [R_W-1:0]    r;

    // operand and coefficient select, unwritten history reads as zero
    always_comb
    begin
        op   = '0;
        coef = '0;
        unique case (ctrl.phase)
            PH_X:
            begin
                op   = x_valid ? OP_W'(x_data) : '0;
                coef = coef_b(ctrl.sel, ctrl.tap);
            end
            PH_YH:
            begin
                op   = y_valid ? OP_W'($signed(y_data[Y_W-1:HALF_W])) : '0;
                coef = coef_a(ctrl.sel, ctrl.tap);
            end
            PH_YL:
            begin
                op   = y_valid ? OP_W'(y_data[HALF_W-1:0]) : '0;
                coef = coef_a(ctrl.sel, ctrl.tap);
            end
            default:
            begin
                op   = '0;
                coef = '0;
            end
        endcase
    end

    // product valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_en_reg <= 1'b0;
        end
        else
        begin
            prod_en_reg <= ctrl.term;
        end
    end

    // registered product and its weight and sign
    always_ff @(posedge clk)
    begin
        if (ctrl.term)
        begin
            prod_reg     <= coef * op;
            prod_neg_reg <= (ctrl.phase != PH_X);
            prod_hi_reg  <= (ctrl.phase == PH_YH);
        end
        acc_reg <= acc_next;
    end

    // accumulate: feedback terms are subtracted
    always_comb
    begin
        term = ACC_W'(prod_reg);
        if (prod_hi_reg)
        begin
            term = term <<< HALF_W;
        end
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = ROUND_BIAS;
        end
        else if (prod_en_reg)
        begin
            acc_next = prod_neg_reg ? (acc_reg - term) : (acc_reg + term);
        end
    end

    // round by floor shift, then saturate for history and for output
    assign r = acc_reg[ACC_W-1:FRAC_SHIFT];

    always_comb
    begin
        if (r > HMAX)
        begin
            y_hist = HMAX[Y_W-1:0];
        end
        else if (r < HMIN)
        begin
            y_hist = HMIN[Y_W-1:0];
        end
        else
        begin
            y_hist = r[Y_W-1:0];
        end

        sat = (r > OMAX) || (r < OMIN);
        if (r > OMAX)
        begin
            y_out = OMAX[SAMPLE_WIDTH-1:0];
        end
        else if (r < OMIN)
        begin
            y_out = OMIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y_out = r[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

### rtl/core/iir_lowpass_selectable_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_lowpass_selectable_order
// Multi-channel direct-form-I Butterworth low-pass filter of order 2, 4 or 8,
// histories kept in two RAMs as per-channel rings, one shared multiplier.
// ----------------------------------------------------------------------------
//
//  port      dir  handshake     payload
//  --------  ---  ------------  -------------------------------------------
//  samples   in   valid/ready   channel, sample_in (signed Q10.14)
//  filtered  out  valid/ready   channel_out, sample_out, saturated
//  cfg       in   valid/ready   order_select (0 second, 1 fourth, 2 eighth)
//
//  an item is accepted only in idle, so the next one waits until the current
//  one is written back; the single multiplier forms three partial products
//  per tap (x*b, upper and lower half of y*a), only x*b for the newest tap.
//  reset clears the order to second and marks all history entries empty;
//  an order write also empties them and is taken in any cycle.
//  a finished result waits in the output register; the next item is taken
//  meanwhile and stalls only at its own write-back if the result is not taken.
//
module iir_lowpass_selectable_order #(
    parameter int NUM_CHANNELS = iirlp_pkg::NUM_CHANNELS_DEF,
    parameter int MAX_TAPS     = iirlp_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_WIDTH = iirlp_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    iirlp_in_if.sink    samples,
    iirlp_out_if.source filtered,
    iirlp_cfg_if.sink   cfg
);

    import iirlp_pkg::*;

    localparam int DEPTH  = NUM_CHANNELS * MAX_TAPS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SLOT_W = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);

    typedef enum logic [2:0] {
        S_IDLE,   // wait for an item
        S_WRX,    // store the new sample in its ring slot
        S_RD,     // first history read
        S_M0,     // b * x
        S_M1,     // a * upper half of y
        S_M2,     // a * lower half of y
        S_F1,     // last accumulate
        S_FIN     // write back y and hand over the result
    } state_t;

    state_t                         state_reg, state_next;
    logic [1:0]                     order_reg, order_next;
    logic [SLOT_W-1:0]              head_reg [NUM_CHANNELS];
    logic [SLOT_W-1:0]              head_next [NUM_CHANNELS];
    logic [DEPTH-1:0]               vx_reg, vx_next;
    logic [DEPTH-1:0]               vy_reg, vy_next;
    logic [CH_W-1:0]                ch_reg, ch_next;
    logic                           chbit_reg, chbit_next;
    logic signed [SAMPLE_WIDTH-1:0] x_reg, x_next;
    logic [1:0]                     sel_reg, sel_next;
    logic [CNT_W-1:0]               taps_reg, taps_next;
    logic [SLOT_W-1:0]              head_new_reg, head_new_next;
    logic [SLOT_W-1:0]              tap_reg, tap_next;
    logic                           rvx_reg, rvx_next;
    logic                           rvy_reg, rvy_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_ch_reg, out_ch_next;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg, out_sample_next;
    logic                           out_sat_reg, out_sat_next;

    logic                           in_fire;
    logic                           cfg_fire;
    logic [CH_W-1:0]                ch_in;
    logic [1:0]                     sel_c;
    logic [3:0]                     base_c;
    logic [CNT_W-1:0]               taps_c;
    logic [SLOT_W:0]                rd_tap;
    logic [SLOT_W:0]                slot_sum;
    logic [SLOT_W-1:0]              rd_slot;
    logic [AW-1:0]                  base_addr;
    logic [AW-1:0]                  rd_addr;
    logic [AW-1:0]                  wr_addr;
    logic                           x_we;
    logic                           y_we;
    logic                           rd_en;
    mac_ctrl_t                      ctrl;
    logic signed [SAMPLE_WIDTH-1:0] x_rd;
    logic signed [Y_W-1:0]          y_rd;
    logic signed [Y_W-1:0]          y_hist;
    logic signed [SAMPLE_WIDTH-1:0] y_out;
    logic                           y_sat;

    // handshakes
    assign samples.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign in_fire       = samples.valid && samples.ready;
    assign cfg_fire      = cfg.valid && cfg.ready;

    assign filtered.valid       = out_valid_reg;
    assign filtered.channel_out = out_ch_reg;
    assign filtered.sample_out  = out_sample_reg;
    assign filtered.saturated   = out_sat_reg;

    // channel wrap, effective order and tap count
    always_comb
    begin
        ch_in  = (NUM_CHANNELS > 1) ? CH_W'(samples.channel) : '0;
        sel_c  = (order_reg == ORD_FOURTH || order_reg == ORD_EIGHTH) ? order_reg : ORD_SECOND;
        base_c = base_taps(sel_c);
        taps_c = (int'(base_c) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(base_c);
    end

    // ring addressing: tap i of a channel lives at slot (head + i) mod taps
    always_comb
    begin
        rd_tap    = (state_reg == S_RD) ? {1'b0, tap_reg} : ({1'b0, tap_reg} + 1'b1);
        slot_sum  = {1'b0, head_new_reg} + rd_tap;
        rd_slot   = (slot_sum >= (SLOT_W + 1)'(taps_reg))
                    ? SLOT_W'(slot_sum - (SLOT_W + 1)'(taps_reg))
                    : SLOT_W'(slot_sum);
        base_addr = AW'(AW'(ch_reg) * AW'(MAX_TAPS));
        rd_addr   = base_addr + AW'(rd_slot);
        wr_addr   = base_addr + AW'(head_new_reg);
    end

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        order_next      = order_reg;
        head_next       = head_reg;
        vx_next         = vx_reg;
        vy_next         = vy_reg;
        ch_next         = ch_reg;
        chbit_next      = chbit_reg;
        x_next          = x_reg;
        sel_next        = sel_reg;
        taps_next       = taps_reg;
        head_new_next   = head_new_reg;
        tap_next        = tap_reg;
        rvx_next        = rvx_reg;
        rvy_next        = rvy_reg;
        out_valid_next  = out_valid_reg && !filtered.ready;
        out_ch_next     = out_ch_reg;
        out_sample_next = out_sample_reg;
        out_sat_next    = out_sat_reg;
        x_we            = 1'b0;
        y_we            = 1'b0;
        rd_en           = 1'b0;
        ctrl            = '0;
        ctrl.sel        = sel_reg;
        ctrl.tap        = TAP_IDX_W'(tap_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ch_next       = ch_in;
                    chbit_next    = samples.channel;
                    x_next        = samples.sample_in;
                    sel_next      = sel_c;
                    taps_next     = taps_c;
                    head_new_next = (head_reg[ch_in] == '0) ? SLOT_W'(taps_c - 1'b1)
                                                            : (head_reg[ch_in] - 1'b1);
                    state_next    = S_WRX;
                end
            end
            S_WRX:
            begin
                x_we              = 1'b1;
                vx_next[wr_addr]  = 1'b1;
                head_next[ch_reg] = head_new_reg;
                tap_next          = '0;
                state_next        = S_RD;
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                ctrl.clear = 1'b1;
                state_next = S_M0;
            end
            S_M0:
            begin
                ctrl.term  = 1'b1;
                ctrl.phase = PH_X;
                if (tap_reg == '0)
                begin
                    // newest tap has no feedback term
                    rd_en    = 1'b1;
                    tap_next = tap_reg + 1'b1;
                end
                else
                begin
                    state_next = S_M1;
                end
            end
            S_M1:
            begin
                ctrl.term  = 1'b1;
                ctrl.phase = PH_YH;
                state_next = S_M2;
            end
            S_M2:
            begin
                ctrl.term  = 1'b1;
                ctrl.phase = PH_YL;
                if ((CNT_W'(tap_reg) + CNT_W'(1)) < taps_reg)
                begin
                    rd_en      = 1'b1;
                    tap_next   = tap_reg + 1'b1;
                    state_next = S_M0;
                end
                else
                begin
                    state_next = S_F1;
                end
            end
            S_F1:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || filtered.ready)
                begin
                    y_we             = 1'b1;
                    vy_next[wr_addr] = 1'b1;
                    out_valid_next   = 1'b1;
                    out_ch_next      = chbit_reg;
                    out_sample_next  = y_out;
                    out_sat_next     = y_sat;
                    state_next       = S_IDLE;
                end
            end
        endcase

        // entry flags travel with the read data
        if (rd_en)
        begin
            rvx_next = vx_reg[rd_addr];
            rvy_next = vy_reg[rd_addr];
        end

        // order write empties all histories
        if (cfg_fire)
        begin
            order_next = cfg.order_select;
            head_next  = '{default: '0};
            vx_next    = '0;
            vy_next    = '0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            order_reg      <= ORD_SECOND;
            head_reg       <= '{default: '0};
            vx_reg         <= '0;
            vy_reg         <= '0;
            ch_reg         <= '0;
            chbit_reg      <= 1'b0;
            x_reg          <= '0;
            sel_reg        <= ORD_SECOND;
            taps_reg       <= '0;
            head_new_reg   <= '0;
            tap_reg        <= '0;
            rvx_reg        <= 1'b0;
            rvy_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_ch_reg     <= 1'b0;
            out_sample_reg <= '0;
            out_sat_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            order_reg      <= order_next;
            head_reg       <= head_next;
            vx_reg         <= vx_next;
            vy_reg         <= vy_next;
            ch_reg         <= ch_next;
            chbit_reg      <= chbit_next;
            x_reg          <= x_next;
            sel_reg        <= sel_next;
            taps_reg       <= taps_next;
            head_new_reg   <= head_new_next;
            tap_reg        <= tap_next;
            rvx_reg        <= rvx_next;
            rvy_reg        <= rvy_next;
            out_valid_reg  <= out_valid_next;
            out_ch_reg     <= out_ch_next;
            out_sample_reg <= out_sample_next;
            out_sat_reg    <= out_sat_next;
        end
    end

    // input history ring
    iirlp_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_x_ram (
        .clk   (clk),
        .we    (x_we),
        .waddr (wr_addr),
        .wdata (x_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (x_rd)
    );

    // output history ring
    iirlp_ram #(
        .WIDTH (Y_W),
        .DEPTH (DEPTH)
    ) u_y_ram (
        .clk   (clk),
        .we    (y_we),
        .waddr (wr_addr),
        .wdata (y_hist),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (y_rd)
    );

    // shared multiply-accumulate
    iirlp_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .x_data  (x_rd),
        .x_valid (rvx_reg),
        .y_data  (y_rd),
        .y_valid (rvy_reg),
        .y_hist  (y_hist),
        .y_out   (y_out),
        .sat     (y_sat)
    );

`ifndef SYNTHESIS
    // the slot of the item at work lies inside the active ring
    a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (CNT_W'(head_new_reg) < taps_reg))
        else $error("ring slot outside the active taps");

    // the tap counter never runs past the tap count
    a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_M0 || state_reg == S_M1 || state_reg == S_M2)
        |-> (CNT_W'(tap_reg) < taps_reg))
        else $error("tap counter beyond tap count");

    // an order write leaves empty histories behind
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> (head_reg[0] == '0) && (vx_reg == '0) && (vy_reg == '0))
        else $error("order write did not clear the histories");

    // a new result appears only from the write-back step
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result loaded outside write-back");
`endif

endmodule

### tb/tb_iir_lowpass_selectable_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iir_lowpass_selectable_order
// Drives sample items on both channels through every filter order and
// compares each filtered item with a bit-exact software copy of the
// fixed-point direct-form-I filter. The order register is rewritten only
// while the filter is drained. Sender gaps, receiver stalls and one long
// receiver hold-off vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_iir_lowpass_selectable_order;

    import iirlp_pkg::*;

    localparam int NCH  = NUM_CHANNELS_DEF;
    localparam int NTAPS = MAX_TAPS_DEF;
    localparam int SW   = SAMPLE_WIDTH_DEF;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 12;
    localparam int ITEM_LATENCY    = 3 * NTAPS + 3;
    localparam int SETTLE_CYCLES   = 2 * ITEM_LATENCY;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_ITEMS     = 125;

    // order code the block treats as second order
    localparam logic [1:0] ORD_UNUSED = 2'd3;

    localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam longint OUT_HI     = (64'sd1 <<< (SW - 1)) - 64'sd1;
    localparam longint OUT_LO     = -(64'sd1 <<< (SW - 1));
    localparam longint HIST_HI    = 64'sd2147483647;
    localparam longint HIST_LO    = -64'sd2147483648;
    localparam longint ROUND_HALF = 64'sd2147483648;
    localparam longint ONE_Q32    = 64'sd4294967296;

    // butterworth sets in signed Q6.32, rows indexed by order code
    localparam longint FF_COEF [3][9] = '{
        '{64'sd86255828, 64'sd172515951, 64'sd86255828, 0, 0, 0, 0, 0, 0},
        '{64'sd1786706, 64'sd7146826, 64'sd10720238, 64'sd7146826, 64'sd1786706,
          0, 0, 0, 0},
        '{0, 64'sd4295, 64'sd21475, 64'sd42950, 64'sd51540, 64'sd42950,
          64'sd21475, 64'sd4295, 0}
    };
    localparam longint FB_COEF [3][9] = '{
        '{ONE_Q32, -64'sd6704521258, 64'sd2754585865, 0, 0, 0, 0, 0, 0},
        '{ONE_Q32, -64'sd13660736190, 64'sd16583701954, -64'sd9071636649,
          64'sd1882333842, 0, 0, 0, 0},
        '{ONE_Q32, -64'sd27446408685, 64'sd77310863027, -64'sd125288916193,
          64'sd127695283290, -64'sd83776051528, 64'sd34535814847,
          -64'sd8176196097, 64'sd850833021}
    };

    localparam logic signed [SW-1:0] CORNER_SAMPLES [7] = '{
        SMP_MAX, SMP_MIN, 24'sh000000, 24'sh000001, 24'shFFFFFF,
        24'sh555555, 24'shAAAAAA
    };

    localparam logic [1:0] ORDER_PLAN [NUM_PHASES] = '{
        ORD_EIGHTH, ORD_FOURTH, ORD_UNUSED, ORD_SECOND,
        ORD_EIGHTH, ORD_FOURTH, ORD_SECOND, ORD_EIGHTH
    };

    typedef struct {
        logic          channel;
        logic [SW-1:0] sample;
        logic          saturated;
    } filtered_t;

    // bit-exact filter copy and queue of filtered items still to come
    class lowpass_scoreboard;
        logic [1:0] order_code;
        int         x_hist [NCH][NTAPS];
        int         y_hist [NCH][NTAPS];
        filtered_t  pending_filtered [$];
        int         errors;

        function new();
            errors = 0;
            load_order(ORD_SECOND);
        endfunction

        function int pending();
            return pending_filtered.size();
        endfunction

        // a register write also wipes both channels' histories
        function void load_order(logic [1:0] code);
            order_code = code;
            foreach (x_hist[c, i])
            begin
                x_hist[c][i] = 0;
                y_hist[c][i] = 0;
            end
        endfunction

        // run one accepted sample through the filter
        function void note_sample(logic ch, logic signed [SW-1:0] x);
            filtered_t  want;
            logic [1:0] eff;
            int         c, taps, i;
            longint     lo, hi, acc, yv, ylow, kept;

            c = int'(ch) % NCH;
            eff = (order_code == ORD_UNUSED) ? ORD_SECOND : order_code;
            case (eff)
                ORD_FOURTH: taps = 5;
                ORD_EIGHTH: taps = 9;
                default:    taps = 3;
            endcase
            if (taps > NTAPS)
                taps = NTAPS;

            // shift the delay lines of this channel
            for (i = taps - 1; i > 0; i--)
            begin
                x_hist[c][i] = x_hist[c][i-1];
                y_hist[c][i] = y_hist[c][i-1];
            end
            x_hist[c][0] = int'(x);

            // exact sum, feedback split into upper and lower halves
            lo = 0;
            hi = 0;
            for (i = 0; i < taps; i++)
                lo += FF_COEF[eff][i] * longint'(x_hist[c][i]);
            for (i = 1; i < taps; i++)
            begin
                yv   = longint'(y_hist[c][i]);
                ylow = {48'd0, y_hist[c][i][15:0]};
                hi  -= FB_COEF[eff][i] * (yv >>> 16);
                lo  -= FB_COEF[eff][i] * ylow;
            end
            lo += ROUND_HALF;
            acc = (hi + (lo >>> 16)) >>> 16;

            // feedback history keeps a 32 bit saturated copy
            kept = acc;
            if (kept > HIST_HI)
                kept = HIST_HI;
            else if (kept < HIST_LO)
                kept = HIST_LO;
            y_hist[c][0] = kept[31:0];

            // output clipped to the sample width
            want.channel = ch;
            if (acc > OUT_HI)
            begin
                want.sample    = SMP_MAX;
                want.saturated = 1'b1;
            end
            else if (acc < OUT_LO)
            begin
                want.sample    = SMP_MIN;
                want.saturated = 1'b1;
            end
            else
            begin
                want.sample    = acc[SW-1:0];
                want.saturated = 1'b0;
            end
            pending_filtered.push_back(want);
        endfunction

        // compare a filtered item with the oldest prediction
        function void check_filtered(logic ch, logic [SW-1:0] y, logic sat);
            filtered_t want;
            if (pending_filtered.size() == 0)
            begin
                $error("unexpected filtered item: channel_out %0d sample_out %0d",
                       ch, $signed(y));
                errors++;
                return;
            end
            want = pending_filtered.pop_front();
            if (ch !== want.channel)
            begin
                $error("channel_out: expected %0d, actual %0d", want.channel, ch);
                errors++;
            end
            if (y !== want.sample)
            begin
                $error("sample_out: expected %0d, actual %0d",
                       $signed(want.sample), $signed(y));
                errors++;
            end
            if (sat !== want.saturated)
            begin
                $error("saturated: expected %0d, actual %0d", want.saturated, sat);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    iirlp_in_if  #(.SAMPLE_WIDTH(SW)) sample_bus ();
    iirlp_out_if #(.SAMPLE_WIDTH(SW)) filtered_bus ();
    iirlp_cfg_if                      order_bus ();

    lowpass_scoreboard board;
    int   idle_pct;
    int   stall_pct;
    logic hold_off_req;
    int   quiet_cycles;

    iir_lowpass_selectable_order #(
        .NUM_CHANNELS (NCH),
        .MAX_TAPS     (NTAPS),
        .SAMPLE_WIDTH (SW)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (sample_bus),
        .filtered (filtered_bus),
        .cfg      (order_bus)
    );

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        filtered_bus.ready = 1'b0;
        hold_off_req = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                filtered_bus.ready <= 1'b0;
            else if (hold_off_req)
            begin
                filtered_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req <= 1'b0;
            end
            else
                filtered_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // item monitor, scoreboard updates and watchdog
    always @(posedge clk)
    begin
        logic moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (order_bus.valid === 1'b1 && order_bus.ready === 1'b1)
            begin
                board.load_order(order_bus.order_select);
                moved = 1'b1;
            end
            if (sample_bus.valid === 1'b1 && sample_bus.ready === 1'b1)
            begin
                board.note_sample(sample_bus.channel, sample_bus.sample_in);
                moved = 1'b1;
            end
            if (filtered_bus.valid === 1'b1 && filtered_bus.ready === 1'b1)
            begin
                board.check_filtered(filtered_bus.channel_out, filtered_bus.sample_out,
                                     filtered_bus.saturated);
                moved = 1'b1;
            end
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // offer one sample item, with random sender gaps before it
    task automatic send_sample(input logic ch, input logic signed [SW-1:0] x);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid     <= 1'b1;
        sample_bus.channel   <= ch;
        sample_bus.sample_in <= x;
        do
            @(posedge clk);
        while (sample_bus.ready !== 1'b1);
    endtask

    // stop offering and wait until every filtered item is back
    task automatic drain_filter();
        sample_bus.valid <= 1'b0;
        // let the monitor note the item accepted at this edge first
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (ITEM_LATENCY) @(posedge clk);
    endtask

    // write the order register on a drained filter
    task automatic write_order(input logic [1:0] code);
        drain_filter();
        order_bus.valid        <= 1'b1;
        order_bus.order_select <= code;
        do
            @(posedge clk);
        while (order_bus.ready !== 1'b1);
        order_bus.valid <= 1'b0;
    endtask

    // extreme levels half of the time, random otherwise
    function automatic logic signed [SW-1:0] pick_level();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            default: return r[SW-1:0];
        endcase
    endfunction

    // corner values on both channels, then the unused order code
    task automatic run_directed();
        int i;
        for (i = 0; i < 14; i++)
            send_sample(1'(i / 7), CORNER_SAMPLES[i % 7]);
        write_order(ORD_UNUSED);
        for (i = 0; i < 4; i++)
            send_sample(1'(i % 2), (i % 2) ? SMP_MIN : SMP_MAX);
    endtask

    // bursts of steps, random walks, square waves and plain noise
    task automatic run_random(input int n_items);
        int                      sent, len, kind, k, walk, half;
        logic                    ch;
        logic signed [SW-1:0]    lvl_a, lvl_b, x;
        logic [31:0]             r;
        sent = 0;
        while (sent < n_items)
        begin
            kind  = $urandom_range(9);
            ch    = 1'($urandom_range(1));
            len   = $urandom_range(4, 40);
            if (len > n_items - sent)
                len = n_items - sent;
            half  = len / 2;
            lvl_a = pick_level();
            lvl_b = pick_level();
            walk  = int'(lvl_a);
            for (k = 0; k < len; k++)
            begin
                r = $urandom;
                case (kind)
                    0, 1: x = r[SW-1:0];
                    2, 3, 4: x = (k < half) ? lvl_a : lvl_b;
                    5, 6, 7:
                    begin
                        walk = walk + int'($urandom_range(8192)) - 4096;
                        if (walk > OUT_HI)
                            walk = int'(OUT_HI);
                        else if (walk < OUT_LO)
                            walk = int'(OUT_LO);
                        x = SW'(walk);
                    end
                    default: x = k[0] ? lvl_a : lvl_b;
                endcase
                // now and then a stray item on the other channel
                if ($urandom_range(3) == 0)
                    send_sample(!ch, r[SW-1:0]);
                else
                    send_sample(ch, x);
                if (kind < 2)
                    ch = 1'($urandom_range(1));
            end
            sent += len;
        end
    endtask

    // main sequence
    initial
    begin
        int p;
        board = new();
        quiet_cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        sample_bus.valid = 1'b0;
        sample_bus.channel = 1'b0;
        sample_bus.sample_in = '0;
        order_bus.valid = 1'b0;
        order_bus.order_select = ORD_SECOND;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
                write_order(2'($urandom_range(3)));
            else
                write_order(ORDER_PLAN[p]);
            // idling mode rotates: none, sender, receiver, both
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 69;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 69;
                end
                default:
                begin
                    idle_pct = 19;
                    stall_pct = 19;
                end
            endcase
            // long receiver hold-off while samples keep coming
            if (p == 0)
                hold_off_req <= 1'b1;
            run_random(PHASE_ITEMS);
        end

        drain_filter();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
